### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they sample on clock and are off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RNH_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// next-cycle implication
`define RNH_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

### design/rnh_pkg.sv
// ---------------------------------------------------------------------------
// rnh_pkg
// Types, codes and sizes shared by the nearest-hit search block.
// ---------------------------------------------------------------------------
package rnh_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int FRAC_BITS   = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int HIT_W       = 7;
   localparam int T_W         = 31;
   localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

   localparam int OPER_W      = 64;
   localparam int PROD_W      = 2 * OPER_W;
   localparam int MUL_DIGIT_W = 8;
   localparam int MUL_STEPS   = OPER_W / MUL_DIGIT_W;
   localparam int ROOT_W      = PROD_W / 2;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int DIV_STEPS   = OPER_W + FRAC_BITS;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_CAST   = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [1:0] KIND_CAMERA = 2'd0;
   localparam logic [1:0] KIND_SPHERE = 2'd1;
   localparam logic [1:0] KIND_PLANE  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         kind;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic [30:0]        radius;
      logic signed [31:0] s_x;
      logic signed [31:0] s_y;
      logic signed [31:0] s_z;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [T_W-1:0]   t_value;
      logic [HIT_W-1:0] hit_index;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic signed [31:0] scalar;
   } entry_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LATCH,
      DP_CLEAR_COUNT,
      DP_ACC_CLEAR,
      DP_APPEND,
      DP_SCAN_INIT,
      DP_ENTRY_INIT,
      DP_MUL_START,
      DP_SQRT_START,
      DP_DIV_START,
      DP_NEXT,
      DP_UPDATE,
      DP_RESPOND
   } dp_op_type;

   typedef enum logic [3:0] {
      MS_NONE,
      MS_PA,
      MS_DD,
      MS_DO,
      MS_OO,
      MS_RR,
      MS_BB,
      MS_AC,
      MS_ND,
      MS_NO
   } mul_sel_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type msel;
      logic [1:0]  k;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic [1:0] kind;
      logic       full;
      logic       scan_end;
      logic       skip;
      logic       ent_plane;
      logic       mul_done;
      logic       sqrt_done;
      logic       div_done;
      logic       a_zero;
      logic       disc_neg;
      logic       num_nonpos;
      logic       plane_miss;
   } dp_status_type;

endpackage

### design/ray_nearest_hit_search.sv
// ---------------------------------------------------------------------------
// ray_nearest_hit_search
// Closest-hit search of a ray against a table of spheres and planes.
// ---------------------------------------------------------------------------
// Use: drive req_data and raise start; the beat is taken at the edge where
// start is high and busy is low. func clears the table, appends an object or
// casts a ray. Only a cast answers: one beat on rsp_data, marked by
// rsp_strobe for a single cycle, the cycle in which busy falls. The receiver
// cannot stall, so it must take the beat in that cycle.
// Work: a plane append runs three products for the offset. A cast visits
// each entry up to the fill count; a skipped entry needs no arithmetic.
// Per-entry time is set by the shared multiplier (8-bit digits, 6 products
// per plane, up to 12 per sphere), the one-bit-a-cycle square root for
// spheres and the fixed-point divider. One request is in flight at a time.
// Reset: fill count cleared, controller idle; table contents are not cleared.
// ---------------------------------------------------------------------------
module ray_nearest_hit_search
   import rnh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rnh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rnh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### design/rnh_mul.sv
// ---------------------------------------------------------------------------
// rnh_mul
// Signed multiplier, one 8-bit digit of the multiplier per cycle.
// ---------------------------------------------------------------------------
module rnh_mul
   import rnh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [OPER_W-1:0] x_op,
   input  logic signed [OPER_W-1:0] y_op,
   output logic                     done,
   output logic signed [PROD_W-1:0] prod
);

   localparam int STEP_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

   logic [OPER_W-1:0] mcand_ff, mcand_in;
   logic [OPER_W-1:0] hi_ff, hi_in;
   logic [OPER_W-1:0] lo_ff, lo_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [OPER_W+MUL_DIGIT_W-1:0] sum;
   logic [PROD_W-1:0] mag;

   always_comb begin
      sum = {{MUL_DIGIT_W{1'b0}}, hi_ff} + mcand_ff * lo_ff[MUL_DIGIT_W-1:0];
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = x_op[OPER_W-1] ? OPER_W'(-x_op) : OPER_W'(x_op);
         lo_in    = y_op[OPER_W-1] ? OPER_W'(-y_op) : OPER_W'(y_op);
         hi_in    = '0;
         neg_in   = x_op[OPER_W-1] ^ y_op[OPER_W-1];
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         hi_in  = sum[OPER_W+MUL_DIGIT_W-1:MUL_DIGIT_W];
         lo_in  = {sum[MUL_DIGIT_W-1:0], lo_ff[OPER_W-1:MUL_DIGIT_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign mag  = {hi_ff, lo_ff};
   assign prod = neg_ff ? -$signed(mag) : $signed(mag);
   assign done = done_ff;

endmodule

### design/rnh_sqrt.sv
// ---------------------------------------------------------------------------
// rnh_sqrt
// Integer square root, restoring form, one root bit per cycle.
// ---------------------------------------------------------------------------
module rnh_sqrt
   import rnh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(SQRT_STEPS);

   logic [PROD_W-1:0] val_ff, val_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [REM_W+1:0]  r2;
   logic [REM_W+1:0]  trial;
   logic              ge;

   always_comb begin
      r2      = {rem_ff, val_ff[PROD_W-1:PROD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = r2 >= trial;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         val_in  = {val_ff[PROD_W-3:0], 2'b00};
         rem_in  = ge ? REM_W'(r2 - trial) : REM_W'(r2);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(SQRT_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### design/rnh_div.sv
// ---------------------------------------------------------------------------
// rnh_div
// Fixed-point divide trunc(n * 2^FRAC_BITS / d), one quotient bit per cycle,
// saturated to the distance range.
// ---------------------------------------------------------------------------
module rnh_div
   import rnh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OPER_W-1:0] num,
   input  logic [OPER_W-1:0] den,
   output logic              done,
   output logic [T_W-1:0]    quo
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic [DIV_STEPS-1:0] num_ff, num_in;
   logic [OPER_W-1:0]    den_ff, den_in;
   logic [OPER_W-1:0]    rem_ff, rem_in;
   logic [T_W-1:0]       quo_ff, quo_in;
   logic                 sat_ff, sat_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [OPER_W:0]      r2;
   logic                 ge;

   always_comb begin
      r2      = {rem_ff, num_ff[DIV_STEPS-1]};
      ge      = r2 >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = {num, {FRAC_BITS{1'b0}}};
         den_in = den;
         rem_in = '0;
         quo_in = '0;
         sat_in = 1'b0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
         rem_in = ge ? OPER_W'(r2 - {1'b0, den_ff}) : OPER_W'(r2);
         quo_in = {quo_ff[T_W-2:0], ge};
         sat_in = sat_ff | quo_ff[T_W-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = sat_ff ? T_MAX : quo_ff;

endmodule

### design/rnh_datapath.sv
// ---------------------------------------------------------------------------
// rnh_datapath
// Object table, request hold, accumulators, arithmetic units and best-hit
// tracking, driven by commands from the controller.
// ---------------------------------------------------------------------------
module rnh_datapath
   import rnh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_strobe,
   output rsp_type       rsp_data
);

   localparam logic signed [OPER_W-1:0] S32_MAX = OPER_W'(64'sh7FFF_FFFF);
   localparam logic signed [OPER_W-1:0] S32_MIN = -OPER_W'(64'sh8000_0000);

   entry_type mem [TABLE_DEPTH];

   req_type                   req_ff;
   entry_type                 ent_ff;
   entry_type                 new_entry;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        idx_ff, idx_in;
   logic signed [OPER_W-1:0]  acc1_ff, acc1_in;
   logic signed [OPER_W-1:0]  acc2_ff, acc2_in;
   logic signed [OPER_W-1:0]  acc3_ff, acc3_in;
   logic signed [PROD_W-1:0]  disc_ff, disc_in;
   logic                      found_ff, found_in;
   logic [T_W-1:0]            best_t_ff, best_t_in;
   logic [COUNT_W-1:0]        best_i_ff, best_i_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      strobe_ff;

   logic signed [31:0]        ak, bk, pk, nk;
   logic signed [32:0]        ok;
   logic signed [OPER_W-1:0]  mul_x, mul_y;
   logic signed [OPER_W-1:0]  flr;
   logic signed [OPER_W-1:0]  neg_d;
   logic signed [OPER_W-1:0]  sq_ext, near_num, far_num, sph_num;
   logic [OPER_W-1:0]         div_n, div_d;
   logic                      mul_done, sqrt_done, div_done;
   logic signed [PROD_W-1:0]  mul_prod;
   logic [ROOT_W-1:0]         sqrt_root;
   logic [T_W-1:0]            div_q;
   logic                      better;

   function automatic logic signed [31:0] pick3(input logic [1:0] k,
                                                input logic signed [31:0] v0,
                                                input logic signed [31:0] v1,
                                                input logic signed [31:0] v2);
      case (k)
         2'd0:    pick3 = v0;
         2'd1:    pick3 = v1;
         default: pick3 = v2;
      endcase
   endfunction

   always_comb begin
      ak = pick3(cmd.k, req_ff.a_x, req_ff.a_y, req_ff.a_z);
      bk = pick3(cmd.k, req_ff.b_x, req_ff.b_y, req_ff.b_z);
      pk = pick3(cmd.k, ent_ff.pos_x, ent_ff.pos_y, ent_ff.pos_z);
      nk = pick3(cmd.k, ent_ff.norm_x, ent_ff.norm_y, ent_ff.norm_z);
      ok = 33'(ak) - 33'(pk);
      case (cmd.msel)
         MS_PA: begin mul_x = OPER_W'(ak); mul_y = OPER_W'(bk); end
         MS_DD: begin mul_x = OPER_W'(bk); mul_y = OPER_W'(bk); end
         MS_DO: begin mul_x = OPER_W'(bk); mul_y = OPER_W'(ok); end
         MS_OO: begin mul_x = OPER_W'(ok); mul_y = OPER_W'(ok); end
         MS_RR: begin mul_x = OPER_W'(ent_ff.scalar); mul_y = OPER_W'(ent_ff.scalar); end
         MS_BB: begin mul_x = acc2_ff; mul_y = acc2_ff; end
         MS_AC: begin mul_x = acc1_ff; mul_y = acc3_ff; end
         MS_ND: begin mul_x = OPER_W'(nk); mul_y = OPER_W'(bk); end
         MS_NO: begin mul_x = OPER_W'(nk); mul_y = OPER_W'(ak); end
         default: begin mul_x = '0; mul_y = '0; end
      endcase
   end

   rnh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == DP_MUL_START),
      .x_op  (mul_x),
      .y_op  (mul_y),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   rnh_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == DP_SQRT_START),
      .value (disc_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_comb begin
      sq_ext   = $signed(OPER_W'(sqrt_root));
      near_num = -acc2_ff - sq_ext;
      far_num  = -acc2_ff + sq_ext;
      sph_num  = near_num[OPER_W-1] ? far_num : near_num;
      div_d    = acc1_ff[OPER_W-1] ? OPER_W'(-acc1_ff) : OPER_W'(acc1_ff);
      if (ent_ff.kind == KIND_PLANE) begin
         div_n = acc2_ff[OPER_W-1] ? OPER_W'(-acc2_ff) : OPER_W'(acc2_ff);
      end else begin
         div_n = OPER_W'(sph_num);
      end
   end

   rnh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == DP_DIV_START),
      .num   (div_n),
      .den   (div_d),
      .done  (div_done),
      .quo   (div_q)
   );

   always_comb begin
      flr   = mul_prod[OPER_W+FRAC_BITS-1:FRAC_BITS];
      neg_d = -acc2_ff;
      new_entry.kind   = req_ff.kind;
      new_entry.pos_x  = req_ff.a_x;
      new_entry.pos_y  = req_ff.a_y;
      new_entry.pos_z  = req_ff.a_z;
      new_entry.norm_x = req_ff.b_x;
      new_entry.norm_y = req_ff.b_y;
      new_entry.norm_z = req_ff.b_z;
      case (req_ff.kind)
         KIND_SPHERE: new_entry.scalar = $signed({1'b0, req_ff.radius});
         KIND_PLANE: begin
            if (neg_d > S32_MAX) begin
               new_entry.scalar = 32'sh7FFF_FFFF;
            end else if (neg_d < S32_MIN) begin
               new_entry.scalar = 32'sh8000_0000;
            end else begin
               new_entry.scalar = neg_d[31:0];
            end
         end
         default: new_entry.scalar = '0;
      endcase
      better = (div_q != '0) && (!found_ff || (div_q < best_t_ff));
   end

   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      acc1_in   = acc1_ff;
      acc2_in   = acc2_ff;
      acc3_in   = acc3_ff;
      disc_in   = disc_ff;
      found_in  = found_ff;
      best_t_in = best_t_ff;
      best_i_in = best_i_ff;
      rsp_in    = rsp_ff;
      case (cmd.op)
         DP_CLEAR_COUNT: count_in = '0;
         DP_ACC_CLEAR:   acc2_in = '0;
         DP_APPEND:      count_in = count_ff + 1'b1;
         DP_SCAN_INIT: begin
            idx_in    = '0;
            found_in  = 1'b0;
            best_t_in = '0;
            best_i_in = '0;
         end
         DP_ENTRY_INIT: begin
            acc1_in = '0;
            acc2_in = (ent_ff.kind == KIND_PLANE) ? OPER_W'(ent_ff.scalar) : '0;
            acc3_in = '0;
         end
         DP_NEXT: idx_in = idx_ff + 1'b1;
         DP_UPDATE: begin
            idx_in = idx_ff + 1'b1;
            if (better) begin
               found_in  = 1'b1;
               best_t_in = div_q;
               best_i_in = idx_ff;
            end
         end
         DP_RESPOND: begin
            rsp_in.hit       = found_ff;
            rsp_in.t_value   = found_ff ? best_t_ff : '0;
            rsp_in.hit_index = found_ff ? HIT_W'(best_i_ff) : '0;
         end
         default: ;
      endcase
      if (mul_done) begin
         case (cmd.msel)
            MS_PA, MS_DO, MS_NO: acc2_in = acc2_ff + flr;
            MS_DD, MS_ND:        acc1_in = acc1_ff + flr;
            MS_OO:               acc3_in = acc3_ff + flr;
            MS_RR:               acc3_in = acc3_ff - flr;
            MS_BB:               disc_in = mul_prod;
            MS_AC:               disc_in = disc_ff - mul_prod;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LATCH) begin
         req_ff <= req_data;
      end
      if (cmd.op == DP_APPEND) begin
         mem[count_ff[IDX_W-1:0]] <= new_entry;
      end
      ent_ff    <= mem[idx_ff[IDX_W-1:0]];
      idx_ff    <= idx_in;
      acc1_ff   <= acc1_in;
      acc2_ff   <= acc2_in;
      acc3_ff   <= acc3_in;
      disc_ff   <= disc_in;
      found_ff  <= found_in;
      best_t_ff <= best_t_in;
      best_i_ff <= best_i_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= (cmd.op == DP_RESPOND);
      end
   end

   always_comb begin
      status.func       = req_ff.func;
      status.kind       = req_ff.kind;
      status.full       = (count_ff == COUNT_W'(TABLE_DEPTH));
      status.scan_end   = (idx_ff == count_ff);
      status.skip       = (ent_ff.kind == KIND_CAMERA) || (ent_ff.kind == KIND_NONE) ||
                          ((ent_ff.pos_x == req_ff.s_x) && (ent_ff.pos_y == req_ff.s_y) &&
                           (ent_ff.pos_z == req_ff.s_z));
      status.ent_plane  = (ent_ff.kind == KIND_PLANE);
      status.mul_done   = mul_done;
      status.sqrt_done  = sqrt_done;
      status.div_done   = div_done;
      status.a_zero     = (acc1_ff == '0);
      status.disc_neg   = disc_ff[PROD_W-1];
      status.num_nonpos = sph_num[OPER_W-1] || (sph_num == '0);
      status.plane_miss = (acc1_ff == '0) || (acc2_ff == '0) ||
                          (acc1_ff[OPER_W-1] == acc2_ff[OPER_W-1]);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### design/rnh_ctrl.sv
// ---------------------------------------------------------------------------
// rnh_ctrl
// Sequencer: decodes a request, steps through the products of each table
// entry and starts the root and divide units.
// ---------------------------------------------------------------------------
module rnh_ctrl
   import rnh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output logic          busy,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MUL,
      S_MUL_WAIT,
      S_APP_WRITE,
      S_FETCH,
      S_CHECK,
      S_SPH_A,
      S_SPH_DISC,
      S_SQRT_WAIT,
      S_SPH_NUM,
      S_PLN_TEST,
      S_DIV_WAIT,
      S_UPDATE,
      S_RESPOND
   } state_type;

   state_type   state_ff, state_in;
   mul_sel_type msel_ff, msel_in;
   logic [1:0]  k_ff, k_in;
   dp_op_type   op;

   always_comb begin
      state_in = state_ff;
      msel_in  = msel_ff;
      k_in     = k_ff;
      op       = DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = DP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.func)
               FUNC_CLEAR: begin
                  op       = DP_CLEAR_COUNT;
                  state_in = S_IDLE;
               end
               FUNC_APPEND: begin
                  if (status.full || (status.kind == KIND_NONE)) begin
                     state_in = S_IDLE;
                  end else if (status.kind == KIND_PLANE) begin
                     op       = DP_ACC_CLEAR;
                     msel_in  = MS_PA;
                     k_in     = 2'd0;
                     state_in = S_MUL;
                  end else begin
                     state_in = S_APP_WRITE;
                  end
               end
               FUNC_CAST: begin
                  op       = DP_SCAN_INIT;
                  state_in = S_FETCH;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MUL: begin
            op       = DP_MUL_START;
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (status.mul_done) begin
               state_in = S_MUL;
               case (msel_ff)
                  MS_PA: begin
                     if (k_ff == 2'd2) state_in = S_APP_WRITE;
                     else k_in = k_ff + 1'b1;
                  end
                  MS_DD: msel_in = MS_DO;
                  MS_DO: msel_in = MS_OO;
                  MS_OO: begin
                     if (k_ff == 2'd2) begin
                        msel_in = MS_RR;
                     end else begin
                        k_in    = k_ff + 1'b1;
                        msel_in = MS_DD;
                     end
                  end
                  MS_RR: state_in = S_SPH_A;
                  MS_BB: msel_in = MS_AC;
                  MS_AC: state_in = S_SPH_DISC;
                  MS_ND: msel_in = MS_NO;
                  MS_NO: begin
                     if (k_ff == 2'd2) begin
                        state_in = S_PLN_TEST;
                     end else begin
                        k_in    = k_ff + 1'b1;
                        msel_in = MS_ND;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_APP_WRITE: begin
            op       = DP_APPEND;
            state_in = S_IDLE;
         end
         S_FETCH: begin
            state_in = status.scan_end ? S_RESPOND : S_CHECK;
         end
         S_CHECK: begin
            if (status.skip) begin
               op       = DP_NEXT;
               state_in = S_FETCH;
            end else begin
               op       = DP_ENTRY_INIT;
               k_in     = 2'd0;
               msel_in  = status.ent_plane ? MS_ND : MS_DD;
               state_in = S_MUL;
            end
         end
         S_SPH_A: begin
            if (status.a_zero) begin
               op       = DP_NEXT;
               state_in = S_FETCH;
            end else begin
               msel_in  = MS_BB;
               state_in = S_MUL;
            end
         end
         S_SPH_DISC: begin
            if (status.disc_neg) begin
               op       = DP_NEXT;
               state_in = S_FETCH;
            end else begin
               op       = DP_SQRT_START;
               state_in = S_SQRT_WAIT;
            end
         end
         S_SQRT_WAIT: begin
            if (status.sqrt_done) state_in = S_SPH_NUM;
         end
         S_SPH_NUM: begin
            if (status.num_nonpos) begin
               op       = DP_NEXT;
               state_in = S_FETCH;
            end else begin
               op       = DP_DIV_START;
               state_in = S_DIV_WAIT;
            end
         end
         S_PLN_TEST: begin
            if (status.plane_miss) begin
               op       = DP_NEXT;
               state_in = S_FETCH;
            end else begin
               op       = DP_DIV_START;
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            op       = DP_UPDATE;
            state_in = S_FETCH;
         end
         S_RESPOND: begin
            op       = DP_RESPOND;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msel_ff  <= MS_NONE;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         msel_ff  <= msel_in;
         k_ff     <= k_in;
      end
   end

   assign busy     = (state_ff != S_IDLE);
   assign cmd.op   = op;
   assign cmd.msel = msel_ff;
   assign cmd.k    = k_ff;

endmodule

### design/rnh_checker.sv
// ---------------------------------------------------------------------------
// rnh_checker
// Port-level checks of the nearest-hit search block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rnh_checker
   import rnh_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   `RNH_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `RNH_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe)
   `RNH_ASSERT_IMPL(a_strobe_idle, rsp_strobe, !busy)
   `RNH_ASSERT_IMPL(a_miss_zero, rsp_strobe && !rsp_data.hit, (rsp_data.t_value == '0) && (rsp_data.hit_index == '0))
   `RNH_ASSERT_IMPL(a_hit_positive, rsp_strobe && rsp_data.hit, rsp_data.t_value != '0)

endmodule

bind ray_nearest_hit_search rnh_checker u_rnh_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for ray_nearest_hit_search. It builds small scenes of
// cameras, spheres and planes, casts rays at them and compares every answer
// with a bit-exact fixed-point model, or for marked beats with the answer
// in their row. A table of directed beats comes first, then random scenes.
// ---------------------------------------------------------------------------
module tb;
   import rnh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 200000;
   localparam int ITEM_COUNT = 1650;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   entry_type scene_tab [TABLE_DEPTH];
   int        scene_len;
   rsp_type   hit_q [$];
   int        mismatches;
   int        idle_cycles;
   int        beats_sent;

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type want;
   } row_type;

   ray_nearest_hit_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint fix_mul(longint x, longint y);
      logic signed [127:0] p;
      p = x * y;
      return longint'(p >>> FRAC_BITS);
   endfunction

   function automatic logic [T_W-1:0] fix_div(logic [63:0] n, logic [63:0] d);
      logic [127:0] q;
      q = ({64'b0, n} << FRAC_BITS) / d;
      if (q > T_MAX) return T_MAX;
      return q[T_W-1:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [129:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [129:0] sq;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         c = r | (64'd1 << k);
         sq = c * c;
         if (sq <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic [T_W-1:0] sphere_dist(entry_type e, longint org[3],
                                                  longint dir[3]);
      longint              o [3];
      longint              a;
      longint              b;
      longint              c;
      longint              num;
      longint              rad;
      logic signed [129:0] bb;
      logic signed [129:0] ac;
      logic signed [129:0] disc;
      logic [63:0]         sq;
      o[0] = org[0] - longint'(e.pos_x);
      o[1] = org[1] - longint'(e.pos_y);
      o[2] = org[2] - longint'(e.pos_z);
      a = 0;
      b = 0;
      c = 0;
      for (int k = 0; k < 3; k++) begin
         a += fix_mul(dir[k], dir[k]);
         b += fix_mul(dir[k], o[k]);
         c += fix_mul(o[k], o[k]);
      end
      rad = longint'(e.scalar);
      c -= fix_mul(rad, rad);
      if (a == 0) return '0;
      bb = b * b;
      ac = a * c;
      disc = bb - ac;
      if (disc < 0) return '0;
      sq = int_sqrt(disc);
      num = -b - longint'(sq);
      if (num < 0) num = -b + longint'(sq);
      if (num <= 0) return '0;
      return fix_div(num, a);
   endfunction

   function automatic logic [T_W-1:0] plane_dist(entry_type e, longint org[3],
                                                 longint dir[3]);
      longint nv [3];
      longint n;
      longint d;
      nv[0] = e.norm_x;
      nv[1] = e.norm_y;
      nv[2] = e.norm_z;
      n = e.scalar;
      d = 0;
      for (int k = 0; k < 3; k++) begin
         n += fix_mul(nv[k], org[k]);
         d += fix_mul(nv[k], dir[k]);
      end
      if (d == 0 || n == 0 || ((n < 0) == (d < 0))) return '0;
      return fix_div(n < 0 ? -n : n, d < 0 ? -d : d);
   endfunction

   // update the scene and tell whether this beat answers
   function automatic bit apply_beat(req_type r, output rsp_type ans);
      longint    org [3];
      longint    dir [3];
      longint    off;
      entry_type e;
      logic [T_W-1:0] t;
      ans = '0;
      org[0] = r.a_x; org[1] = r.a_y; org[2] = r.a_z;
      dir[0] = r.b_x; dir[1] = r.b_y; dir[2] = r.b_z;
      case (r.func)
         FUNC_CLEAR: begin
            scene_len = 0;
         end
         FUNC_APPEND: begin
            if (scene_len < TABLE_DEPTH && r.kind != KIND_NONE) begin
               e.kind = r.kind;
               e.pos_x = r.a_x; e.pos_y = r.a_y; e.pos_z = r.a_z;
               e.norm_x = r.b_x; e.norm_y = r.b_y; e.norm_z = r.b_z;
               e.scalar = '0;
               if (r.kind == KIND_SPHERE) e.scalar = {1'b0, r.radius};
               if (r.kind == KIND_PLANE) begin
                  off = -(fix_mul(org[0], dir[0]) + fix_mul(org[1], dir[1]) +
                          fix_mul(org[2], dir[2]));
                  if (off > 64'sh7FFFFFFF) off = 64'sh7FFFFFFF;
                  if (off < -64'sh80000000) off = -64'sh80000000;
                  e.scalar = off[31:0];
               end
               scene_tab[scene_len] = e;
               scene_len++;
            end
         end
         FUNC_CAST: begin
            for (int i = 0; i < scene_len; i++) begin
               e = scene_tab[i];
               if (e.kind == KIND_CAMERA) continue;
               if (e.pos_x == r.s_x && e.pos_y == r.s_y && e.pos_z == r.s_z) continue;
               t = (e.kind == KIND_SPHERE) ? sphere_dist(e, org, dir)
                                           : plane_dist(e, org, dir);
               if (t > 0 && (!ans.hit || t < ans.t_value)) begin
                  ans.hit = 1'b1;
                  ans.t_value = t;
                  ans.hit_index = i[HIT_W-1:0];
               end
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
      mismatches++;
   endtask

   // hold start until the beat is taken; decide acceptance at the falling edge
   task automatic send_beat(req_type r, int gap, bit fixed = 0, rsp_type want = '0);
      rsp_type ans;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      if (apply_beat(r, ans)) hit_q.push_back(fixed ? want : ans);
      beats_sent++;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
   endfunction

   function automatic req_type rand_beat(logic [1:0] func);
      req_type   r;
      entry_type e;
      int        sh;
      r = '0;
      r.func = func;
      r.kind = 2'($urandom_range(0, 3));
      r.a_x = rand_coord(); r.a_y = rand_coord(); r.a_z = rand_coord();
      r.s_x = rand_coord(); r.s_y = rand_coord(); r.s_z = rand_coord();
      r.radius = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 4 << 16));
      r.b_x = rand_coord(); r.b_y = rand_coord(); r.b_z = rand_coord();
      if (func == FUNC_APPEND) begin
         r.kind = ($urandom_range(0, 15) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
         if (r.kind == KIND_PLANE && $urandom_range(0, 3) != 0) begin
            r.b_x = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
            r.b_y = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
            r.b_z = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
         end
         if (scene_len > 0 && $urandom_range(0, 9) == 0) begin
            e = scene_tab[scene_len - 1];
            r.kind = e.kind;
            r.a_x = e.pos_x; r.a_y = e.pos_y; r.a_z = e.pos_z;
            r.b_x = e.norm_x; r.b_y = e.norm_y; r.b_z = e.norm_z;
            r.radius = e.scalar[30:0];
         end
      end
      if (func == FUNC_CAST && scene_len > 0) begin
         e = scene_tab[$urandom_range(0, scene_len - 1)];
         if ($urandom_range(0, 3) != 0) begin
            sh = $urandom_range(0, 4);
            r.b_x = 32'((longint'(e.pos_x) - longint'(r.a_x)) >>> sh);
            r.b_y = 32'((longint'(e.pos_y) - longint'(r.a_y)) >>> sh);
            r.b_z = 32'((longint'(e.pos_z) - longint'(r.a_z)) >>> sh);
         end
         if ($urandom_range(0, 9) == 0) begin
            r.b_x = $signed($urandom_range(0, 600)) - 300;
            r.b_y = $signed($urandom_range(0, 600)) - 300;
            r.b_z = $signed($urandom_range(0, 600)) - 300;
         end
         if ($urandom_range(0, 5) == 0) begin
            r.s_x = e.pos_x; r.s_y = e.pos_y; r.s_z = e.pos_z;
         end
      end
      return r;
   endfunction

   function automatic req_type mk(logic [1:0] func, logic [1:0] kind,
                                  logic signed [31:0] ax, ay, az, bx, by, bz,
                                  logic [30:0] rad = '0,
                                  logic signed [31:0] sx = 32'sh7FFF0000,
                                  logic signed [31:0] sy = 0, logic signed [31:0] sz = 0);
      req_type r;
      r.func = func; r.kind = kind;
      r.a_x = ax; r.a_y = ay; r.a_z = az;
      r.b_x = bx; r.b_y = by; r.b_z = bz;
      r.radius = rad;
      r.s_x = sx; r.s_y = sy; r.s_z = sz;
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (hit_q.size() == 0) begin
            report("unexpected beat", rsp_data, 0);
         end else begin
            want = hit_q.pop_front();
            if (rsp_data.hit !== want.hit) report("hit", rsp_data.hit, want.hit);
            if (rsp_data.t_value !== want.t_value)
               report("t_value", rsp_data.t_value, want.t_value);
            if (rsp_data.hit_index !== want.hit_index)
               report("hit_index", rsp_data.hit_index, want.hit_index);
         end
      end
      if (reset || (start && !busy) || rsp_strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      row_type row;
      rsp_type miss;
      rsp_type want;
      int      nobj;
      int      ncast;
      int      gap;
      bit      big_done;
      bit      hold_done;
      localparam logic signed [31:0] ONE  = 32'sh00010000;
      localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
      localparam logic signed [31:0] MINV = -32'sh80000000;

      mismatches = 0;
      idle_cycles = 0;
      beats_sent = 0;
      scene_len = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      miss = '0;
      want = '0;
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE), 1, miss});
      rows.push_back('{mk(FUNC_NONE, KIND_NONE, MAXV, MINV, MAXV, MINV, MAXV, MINV, '1), 0, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_CAMERA, 0, 0, 0, 0, 0, 0), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE), 1, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_SPHERE, 0, 0, 10 * ONE, 0, 0, 0, ONE), 0, miss});
      want = '{hit: 1'b1, t_value: 31'(9 * ONE), hit_index: 7'd1};
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE), 1, want});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE, 0, 0, 0, 10 * ONE),
                       1, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_PLANE, 0, 0, 5 * ONE, 0, 0, -ONE), 0, miss});
      want = '{hit: 1'b1, t_value: 31'(5 * ONE), hit_index: 7'd2};
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE), 1, want});
      rows.push_back('{mk(FUNC_APPEND, KIND_PLANE, 0, 0, 5 * ONE, 0, 0, -ONE), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_SPHERE, 0, 0, 0, 0, 0, ONE), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 10 * ONE, 0, 0, ONE), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, 0), 1, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 1, 1, 1), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 256, 0, 256), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, ONE, 0, 0), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 3 * ONE, 0, 0, 0, ONE), 0, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_NONE, 1, 2, 3, 4, 5, 6), 0, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_SPHERE, MAXV, MINV, MAXV, MINV, MAXV, MINV, '1),
                       0, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_PLANE, MINV, MINV, MINV, MINV, MINV, MINV), 0, miss});
      rows.push_back('{mk(FUNC_APPEND, KIND_PLANE, MAXV, MAXV, MAXV, MINV, MINV, MINV), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_NONE, MINV, MAXV, MINV, MAXV, MINV, MAXV, '1,
                       MAXV, MINV, MAXV), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, MAXV, MAXV, MAXV, MINV, MINV, MINV), 0, miss});
      rows.push_back('{mk(FUNC_CLEAR, KIND_NONE, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, '1), 0, miss});
      rows.push_back('{mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE), 1, miss});

      foreach (rows[i]) begin
         row = rows[i];
         send_beat(row.r, $urandom_range(0, 17), row.fixed, row.want);
      end

      big_done = 0;
      hold_done = 0;
      while (beats_sent < ITEM_COUNT) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : -1;
         if (scene_len >= 6 || $urandom_range(0, 3) == 0)
            send_beat(rand_beat($urandom_range(0, 7) == 0 ? FUNC_NONE : FUNC_CLEAR),
                      gap < 0 ? $urandom_range(0, 17) : 0);
         if (!big_done && beats_sent > ITEM_COUNT / 2) begin
            // fill the table, overflow it, then search past the cameras
            big_done = 1;
            send_beat(rand_beat(FUNC_CLEAR), 0);
            for (int i = 0; i < TABLE_DEPTH - 1; i++)
               send_beat(mk(FUNC_APPEND, KIND_CAMERA, i, 0, 0, 0, 0, 0), 0);
            send_beat(mk(FUNC_APPEND, KIND_SPHERE, 0, 0, 10 * ONE, 0, 0, 0, ONE), 0);
            send_beat(mk(FUNC_APPEND, KIND_PLANE, 0, 0, 5 * ONE, 0, 0, -ONE), 0);
            send_beat(mk(FUNC_CAST, KIND_CAMERA, 0, 0, 0, 0, 0, ONE), 0);
            send_beat(rand_beat(FUNC_CLEAR), 0);
         end
         if (!hold_done && beats_sent > ITEM_COUNT / 3) begin
            // drop start and wait until every answer is back
            hold_done = 1;
            start <= 1'b0;
            @(posedge clock);
            while (hit_q.size() > 0) @(posedge clock);
         end
         nobj = $urandom_range(0, 4);
         for (int i = 0; i < nobj; i++)
            send_beat(rand_beat(FUNC_APPEND), gap < 0 ? $urandom_range(0, 17) : 0);
         ncast = $urandom_range(1, 3);
         for (int i = 0; i < ncast; i++)
            send_beat(rand_beat(FUNC_CAST), gap < 0 ? $urandom_range(0, 17) : 0);
      end
      start <= 1'b0;

      while (hit_q.size() > 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### ray_nearest_hit_search.f
+incdir+design
design/rnh_pkg.sv
design/rnh_mul.sv
design/rnh_sqrt.sv
design/rnh_div.sv
design/rnh_datapath.sv
design/rnh_ctrl.sv
design/ray_nearest_hit_search.sv
design/rnh_checker.sv
test/tb.sv
